// ===== sv/itra_pkg.sv =====
// ----------------------------------------------------------------------------
// itra_pkg
// Shared constants, types and the digit-to-ASCII mapping for the integer to
// radix ASCII converter.
// ----------------------------------------------------------------------------
package itra_pkg;

  localparam int unsigned ValueInW       = 64;
  localparam int unsigned BaseW          = 6;
  localparam int unsigned CharW          = 7;
  localparam int unsigned ValueWidthDef  = 64;
  localparam int unsigned MaxDigitsDef   = 64;

  localparam logic [CharW-1:0] AsciiZero = 7'd48;
  localparam logic [BaseW-1:0] DecLimit  = 6'd9;
  localparam logic [CharW-1:0] AlphaGap  = 7'd7;
  localparam logic [BaseW-1:0] MinBase   = 6'd2;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_DIV  = 6'b000010,
    S_STOR = 6'b000100,
    S_READ = 6'b001000,
    S_EMIT = 6'b010000,
    S_ERR  = 6'b100000
  } itra_state_e;

  typedef struct packed {
    logic load_in;
    logic div_step;
    logic store;
    logic rd_en;
    logic emit_load;
    logic err_load;
  } itra_cmd_t;

  typedef struct packed {
    logic base_bad;
    logic div_last;
    logic quot_zero;
    logic buf_full;
    logic rd_first;
    logic out_free;
  } itra_sts_t;

  function automatic logic [CharW-1:0] to_char(input logic [BaseW-1:0] rem);
    logic [CharW-1:0] c;
    c = AsciiZero + {1'b0, rem};
    if (rem > DecLimit) begin
      c = c + AlphaGap;
    end
    return c;
  endfunction

endpackage

// ===== sv/itra_ctrl.sv =====
// ----------------------------------------------------------------------------
// itra_ctrl
// Sequencer for the converter: runs the serial divider once per digit, then
// reads the digit buffer back in reverse order into the output register.
// ----------------------------------------------------------------------------
module itra_ctrl
  import itra_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  itra_sts_t sts_i,
  output itra_cmd_t cmd_o
);

  itra_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d = sts_i.base_bad ? S_ERR : S_DIV;
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = S_STOR;
        end
      end
      S_STOR: begin
        cmd_o.store = 1'b1;
        state_d = (sts_i.quot_zero || sts_i.buf_full) ? S_READ : S_DIV;
      end
      S_READ: begin
        cmd_o.rd_en = 1'b1;
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit_load = 1'b1;
          state_d = sts_i.rd_first ? S_IDLE : S_READ;
        end
      end
      S_ERR: begin
        if (sts_i.out_free) begin
          cmd_o.err_load = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

// ===== sv/itra_dp.sv =====
// ----------------------------------------------------------------------------
// itra_dp
// Datapath: restoring bit-serial divider, digit buffer memory and the output
// register that holds one digit until the downstream side takes it.
// ----------------------------------------------------------------------------
module itra_dp
  import itra_pkg::*;
#(
  parameter int unsigned VALUE_WIDTH = ValueWidthDef,
  parameter int unsigned MAX_DIGITS  = MaxDigitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [ValueInW-1:0] value_i,
  input  logic [BaseW-1:0]    base_i,
  input  logic                out_stall_i,
  output logic                out_valid_o,
  output logic [CharW-1:0]    digit_char_o,
  output logic                last_o,
  output logic                error_o,
  input  itra_cmd_t           cmd_i,
  output itra_sts_t           sts_o
);

  localparam int unsigned AddrW = $clog2(MAX_DIGITS);
  localparam int unsigned CntW  = $clog2(VALUE_WIDTH);

  logic [BaseW-1:0]       base_q;
  logic [VALUE_WIDTH-1:0] quot_q;
  logic [BaseW-1:0]       rem_q;
  logic [CntW-1:0]        bitcnt_q;
  logic [AddrW-1:0]       wr_idx_q;
  logic [AddrW-1:0]       rd_idx_q;
  logic [BaseW-1:0]       rd_data_q;
  logic [BaseW-1:0]       digit_mem [MAX_DIGITS];

  logic                   out_valid_q;
  logic [CharW-1:0]       out_char_q;
  logic                   out_last_q;
  logic                   out_err_q;

  logic [BaseW:0]         trial;
  logic [BaseW:0]         trial_sub;
  logic                   trial_ge;

  // One restoring step: shift in the next dividend bit and subtract if it fits.
  assign trial     = {rem_q, quot_q[VALUE_WIDTH-1]};
  assign trial_sub = trial - {1'b0, base_q};
  assign trial_ge  = trial >= {1'b0, base_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      base_q   <= base_i;
      quot_q   <= value_i[VALUE_WIDTH-1:0];
      rem_q    <= '0;
      bitcnt_q <= CntW'(VALUE_WIDTH - 1);
      wr_idx_q <= '0;
    end else if (cmd_i.div_step) begin
      rem_q    <= trial_ge ? trial_sub[BaseW-1:0] : trial[BaseW-1:0];
      quot_q   <= {quot_q[VALUE_WIDTH-2:0], trial_ge};
      bitcnt_q <= bitcnt_q - 1'b1;
    end else if (cmd_i.store) begin
      rem_q    <= '0;
      bitcnt_q <= CntW'(VALUE_WIDTH - 1);
      wr_idx_q <= wr_idx_q + 1'b1;
    end
  end

  // The last stored digit is the most significant one; read back from there.
  always_ff @(posedge clk_i) begin
    if (cmd_i.store) begin
      rd_idx_q <= wr_idx_q;
    end else if (cmd_i.emit_load && (rd_idx_q != '0)) begin
      rd_idx_q <= rd_idx_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.store) begin
      digit_mem[wr_idx_q] <= rem_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      rd_data_q <= digit_mem[rd_idx_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit_load || cmd_i.err_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_load) begin
      out_char_q <= to_char(rd_data_q);
      out_last_q <= (rd_idx_q == '0);
      out_err_q  <= 1'b0;
    end else if (cmd_i.err_load) begin
      out_char_q <= '0;
      out_last_q <= 1'b1;
      out_err_q  <= 1'b1;
    end
  end

  assign sts_o.base_bad  = base_i < MinBase;
  assign sts_o.div_last  = (bitcnt_q == '0);
  assign sts_o.quot_zero = (quot_q == '0);
  assign sts_o.buf_full  = (wr_idx_q == AddrW'(MAX_DIGITS - 1));
  assign sts_o.rd_first  = (rd_idx_q == '0);
  assign sts_o.out_free  = !out_valid_q || !out_stall_i;

  assign out_valid_o  = out_valid_q;
  assign digit_char_o = out_char_q;
  assign last_o       = out_last_q;
  assign error_o      = out_err_q;

endmodule

// ===== sv/int_to_radix_ascii.sv =====
// Each digit comes from the serial divider and goes to the digit buffer; the
// buffer is then read back, most significant digit first, into the output.
// A request of up to MAX_DIGITS digits is finished before the next is taken.
// A base below two loads an error result once the output register is free.
// One request is worked at a time; the divider makes one quotient bit per cycle.
// Reset is asynchronous and active low; it returns the sequencer to idle.
// ----------------------------------------------------------------------------
// int_to_radix_ascii
// Converts an unsigned value to its ASCII digits in a given base, most
// significant digit first, with the final digit marked.
// ----------------------------------------------------------------------------
module int_to_radix_ascii
  import itra_pkg::*;
#(
  parameter int unsigned VALUE_WIDTH = ValueWidthDef,
  parameter int unsigned MAX_DIGITS  = MaxDigitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [ValueInW-1:0] value_i,
  input  logic [BaseW-1:0]    base_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [CharW-1:0]    digit_char_o,
  output logic                last_o,
  output logic                error_o
);

  itra_cmd_t cmd;
  itra_sts_t sts;

  itra_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  itra_dp #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .MAX_DIGITS  (MAX_DIGITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .value_i      (value_i),
    .base_i       (base_i),
    .out_stall_i  (out_stall_i),
    .out_valid_o  (out_valid_o),
    .digit_char_o (digit_char_o),
    .last_o       (last_o),
    .error_o      (error_o),
    .cmd_i        (cmd),
    .sts_o        (sts)
  );

endmodule

// ===== sv/itra_checker.sv =====
// ----------------------------------------------------------------------------
// itra_checker
// Port-level checks for the converter, bound to the top level.
// ----------------------------------------------------------------------------
module itra_checker
  import itra_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input logic [ValueInW-1:0] value_i,
  input logic [BaseW-1:0]    base_i,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input logic [CharW-1:0]    digit_char_o,
  input logic                last_o,
  input logic                error_o
);

  // A stalled request holds its fields.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(value_i) && $stable(base_i))
    else $error("stalled request changed");

  // A stalled result holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(digit_char_o)
      && $stable(last_o) && $stable(error_o))
    else $error("stalled result changed");

  // An error result is a lone, final result with a zero character.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && error_o |-> last_o && (digit_char_o == '0))
    else $error("malformed error result");

  // Digits are '0'..'9' or start at 'A', after the gap that follows '9'.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !error_o |-> (digit_char_o >= 7'd48) && (digit_char_o <= 7'd118)
      && !((digit_char_o > 7'd57) && (digit_char_o < 7'd65)))
    else $error("digit character out of range");

  // One request is worked at a time, so an accepted request stalls the input.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not stalled after a request");

endmodule

bind int_to_radix_ascii itra_checker u_itra_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .value_i      (value_i),
  .base_i       (base_i),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .digit_char_o (digit_char_o),
  .last_o       (last_o),
  .error_o      (error_o)
);

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the integer to radix ASCII converter. Each accepted
// request is expanded into its expected digit stream by a local predictor,
// and every digit leaving the block is compared against the oldest pending
// one. Directed corner cases come first, then random requests with random
// idling on both sides, a long output hold-off and a full drain pause.
// ----------------------------------------------------------------------------
module tb_top;
  import itra_pkg::*;

  localparam int unsigned DigitCap   = MaxDigitsDef;
  localparam int unsigned RandomReqs = 128;

  typedef struct {
    logic [CharW-1:0] digit;
    logic             last;
    logic             err;
  } digit_t;

  class digit_ledger;
    digit_t pending[$];
    int     digits_seen;
    int     requests;
    int     bad_bases;
    int     mismatches;

    function new();
      digits_seen = 0;
      requests    = 0;
      bad_bases   = 0;
      mismatches  = 0;
    endfunction

    // Expands one request into its digits, most significant first, or into an error result for a bad base.
    function void note_request(logic [ValueInW-1:0] value, logic [BaseW-1:0] base);
      logic [ValueInW-1:0] quot;
      logic [BaseW-1:0]    rems[DigitCap];
      logic [CharW-1:0]    ch;
      digit_t              d;
      int                  n;
      requests++;
      if (base < MinBase) begin
        bad_bases++;
        d.digit = '0;
        d.last  = 1'b1;
        d.err   = 1'b1;
        pending.push_back(d);
        return;
      end
      quot = value;
      n    = 0;
      do begin
        rems[n] = BaseW'(quot % ValueInW'(base));
        quot    = quot / ValueInW'(base);
        n++;
      end while (quot != 0 && n < DigitCap);
      for (int k = n - 1; k >= 0; k--) begin
        ch = AsciiZero + CharW'(rems[k]);
        if (rems[k] > DecLimit) begin
          ch = ch + AlphaGap;
        end
        d.digit = ch;
        d.last  = (k == 0);
        d.err   = 1'b0;
        pending.push_back(d);
      end
    endfunction

    function void check_digit(logic [CharW-1:0] digit, logic last, logic err);
      digit_t exp_d;
      digits_seen++;
      if (pending.size() == 0) begin
        $error("unexpected digit: digit_char %0d last %0b error %0b", digit, last, err);
        mismatches++;
        return;
      end
      exp_d = pending.pop_front();
      if (digit !== exp_d.digit) begin
        $error("digit_char mismatch: expected %0d, actual %0d", exp_d.digit, digit);
        mismatches++;
      end
      if (last !== exp_d.last) begin
        $error("last mismatch: expected %0b, actual %0b", exp_d.last, last);
        mismatches++;
      end
      if (err !== exp_d.err) begin
        $error("error mismatch: expected %0b, actual %0b", exp_d.err, err);
        mismatches++;
      end
    endfunction

    function bit drained();
      return pending.size() == 0;
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  logic [ValueInW-1:0] value_i;
  logic [BaseW-1:0]    base_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic [CharW-1:0]    digit_char_o;
  logic                last_o;
  logic                error_o;

  digit_ledger board = new();
  bit          sender_steady;
  int          input_stalls;

  int_to_radix_ascii DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .value_i     (value_i),
    .base_i      (base_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .digit_char_o(digit_char_o),
    .last_o      (last_o),
    .error_o     (error_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    value_i     = '0;
    base_i      = '0;
    out_stall_i = 1'b0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
  end

  // Output monitor: digits are taken at the rising edge they are accepted.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      board.check_digit(digit_char_o, last_o, error_o);
    end
  end

  // Receiver: random stalls, one long hold-off, and a quiet stretch.
  initial begin
    int  hold_left;
    bit  hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!hold_done && board.digits_seen >= 100) begin
        hold_done = 1'b1;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (board.digits_seen >= 300 && board.digits_seen < 600) begin
        out_stall_i <= 1'b0;
      end else begin
        out_stall_i <= ($urandom_range(0, 99) < 26);
      end
    end
  end

  task automatic send_request(logic [ValueInW-1:0] value, logic [BaseW-1:0] base);
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    value_i    <= value;
    base_i     <= base;
    @(posedge clk_i);
    while (in_stall_o) begin
      input_stalls++;
      @(posedge clk_i);
    end
    board.note_request(value, base);
  endtask

  task automatic sender_gap();
    int n;
    if (!sender_steady && $urandom_range(0, 99) < 26) begin
      n = $urandom_range(1, 4);
      repeat (n) begin
        @(negedge clk_i);
        in_valid_i <= 1'b0;
        value_i    <= {$urandom, $urandom};
        base_i     <= BaseW'($urandom);
      end
    end
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (!board.drained()) @(posedge clk_i);
  endtask

  initial begin
    logic [ValueInW-1:0] v;
    logic [BaseW-1:0]    b;
    int                  nbits;
    int                  pick;
    sender_steady = 1'b0;
    input_stalls  = 0;
    @(posedge rst_ni);
    @(posedge clk_i);

    // Directed corner cases.
    send_request(64'd12345, 6'd0);
    send_request({64{1'b1}}, 6'd1);
    send_request(64'd0, 6'd10);
    send_request(64'd0, 6'd1);
    send_request(64'd1, 6'd2);
    send_request({64{1'b1}}, 6'd2);
    send_request({64{1'b1}}, 6'd63);
    send_request({64{1'b1}}, 6'd10);
    send_request(64'h9A, 6'd16);
    send_request(64'd35, 6'd36);
    send_request(64'd36, 6'd37);
    send_request(64'd62, 6'd63);
    send_request(64'd63, 6'd63);
    send_request(64'h5555_5555_5555_5555, 6'd2);
    send_request(64'hAAAA_AAAA_AAAA_AAAA, 6'd3);
    send_request(64'h8000_0000_0000_0000, 6'd62);
    send_request(64'd1, 6'd63);
    wait_drained();

    for (int i = 0; i < RandomReqs; i++) begin
      sender_steady = (i >= 50 && i < 80);
      nbits = $urandom_range(1, 64);
      v     = {$urandom, $urandom};
      if (nbits < 64) begin
        v = v & ((64'd1 << nbits) - 64'd1);
      end
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        b = BaseW'($urandom_range(0, 1));
      end else if (pick < 14) begin
        b = 6'd2;
      end else begin
        b = BaseW'($urandom_range(2, 63));
      end
      send_request(v, b);
      // Let the whole pipeline empty once in the middle of the random part.
      if (i == 90) begin
        wait_drained();
      end
      sender_gap();
    end

    wait_drained();
    repeat (200) @(posedge clk_i);
    if (!board.drained()) begin
      $error("%0d expected digits never arrived", board.pending.size());
      board.mismatches++;
    end
    $display("Summary: %0d requests (%0d with a bad base), %0d digits checked.",
             board.requests, board.bad_bases, board.digits_seen);
    $display("Summary: %0d input stall cycles seen, %0d mismatches.",
             input_stalls, board.mismatches);
    if (board.mismatches == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

  initial begin
    #12_000_000;
    $display("tb_top: FAIL");
    $finish;
  end

endmodule
